FILE: sv/cup_pkg.sv
// Shared constants for the card UID frame parser.
package cup_pkg;

	localparam int FRAME_LENGTH = 26;
	localparam int UID_OFFSET   = 7;

	localparam int POS_W = 6;
	localparam int IDX_W = POS_W + 1;

	localparam logic [IDX_W-1:0] FRAME_LEN_W  = IDX_W'(FRAME_LENGTH);
	localparam logic [IDX_W-1:0] HDR_LEN_W    = IDX_W'(4);

	localparam logic [7:0] HDR_BYTE2 = 8'h15;
	localparam logic [7:0] HDR_BYTE3 = 8'h00;

	localparam logic [16:0] ELAPSED_MAX = 17'h10000;

	localparam logic [7:0]  START_RESET  = 8'hAA;
	localparam logic [7:0]  STATION_RESET = 8'h00;
	localparam logic [15:0] WINDOW_RESET = 16'd1000;

	localparam logic [1:0] ST_STORED       = 2'd0;
	localparam logic [1:0] ST_CONFIRMED    = 2'd1;
	localparam logic [1:0] ST_BAD_CHECKSUM = 2'd2;

	localparam logic [1:0] REG_START   = 2'd0;
	localparam logic [1:0] REG_STATION = 2'd1;
	localparam logic [1:0] REG_WINDOW  = 2'd2;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

endpackage

FILE: sv/card_uid_frame_parser.sv
// Card UID frame parser: header match, XOR block check and repeat confirmation.
//
// Takes one transaction per cycle on the input channel while it is not stalled,
// each either a received byte or a one millisecond tick. An item is captured in
// the input register and processed from there once the result register can
// advance; the result of a frame's last byte is loaded into the result register,
// which drives the output. The result register holds a pending result while the
// next item is accepted; the input side stalls only when both the input register
// and the result register are full and the result is not taken.
// A result (status and UID) is produced only on the last byte of a frame.
// Configuration writes are taken in any cycle and are meant to happen while the
// block is idle.
module card_uid_frame_parser
	import cup_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] card_uid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  byte_s1;

	logic [7:0]  start_q;
	logic [7:0]  station_q;
	logic [15:0] window_q;

	logic [POS_W-1:0] pos_q;
	logic [7:0]  xor_q;
	logic [31:0] uid_q;
	logic        good_q;
	logic [31:0] prev_uid_q;
	logic [16:0] elapsed_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] card_uid_q;

	logic        advance;
	logic        fire_s1;
	logic        byte_fire;

	logic [IDX_W-1:0] idx;
	logic [7:0]  expect_byte;
	logic        hdr_bad;
	logic [7:0]  xor_next;
	logic [31:0] uid_next;
	logic        good_next;
	logic        last_byte;
	logic        store_new;
	logic [1:0]  status_next;

	assign advance   = !out_valid_q || out_ready;
	assign fire_s1   = valid_s1 && advance;
	assign byte_fire = fire_s1 && (kind_s1 == KIND_BYTE);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign card_uid  = card_uid_q;

	assign idx = {1'b0, pos_q};

	always_comb begin
		case (pos_q[1:0])
			2'd0:    expect_byte = start_q;
			2'd1:    expect_byte = station_q;
			2'd2:    expect_byte = HDR_BYTE2;
			default: expect_byte = HDR_BYTE3;
		endcase
	end

	always_comb begin
		logic [7:0]  xor_base;
		logic [31:0] uid_base;
		logic        good_base;
		xor_base  = (idx == '0) ? 8'h00 : xor_q;
		uid_base  = (idx == '0) ? 32'h0 : uid_q;
		good_base = (idx == '0) ? 1'b0 : good_q;

		hdr_bad = (idx < HDR_LEN_W) && (byte_s1 != expect_byte);

		// Bytes 1 up to FRAME_LENGTH-3 feed the block check.
		xor_next = xor_base;
		if (!hdr_bad && (idx >= IDX_W'(1)) && ((idx + IDX_W'(3)) <= FRAME_LEN_W)) begin
			xor_next = xor_base ^ byte_s1;
		end

		good_next = good_base;
		if (!hdr_bad && ((idx + IDX_W'(2)) == FRAME_LEN_W)) begin
			good_next = (xor_next == byte_s1);
		end

		uid_next = uid_base;
		for (int k = 0; k < 4; k++) begin
			if (!hdr_bad && (idx == IDX_W'(UID_OFFSET + k))) begin
				uid_next[31 - 8*k -: 8] = byte_s1;
			end
		end

		last_byte = !hdr_bad && ((idx + IDX_W'(1)) >= FRAME_LEN_W);

		store_new = (uid_next != prev_uid_q) || (elapsed_q > {1'b0, window_q});
		if (!good_next) begin
			status_next = ST_BAD_CHECKSUM;
		end else if (store_new) begin
			status_next = ST_STORED;
		end else begin
			status_next = ST_CONFIRMED;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			byte_s1 <= rx_byte;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= START_RESET;
			station_q <= STATION_RESET;
			window_q  <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START:   start_q   <= cfg_data[7:0];
				REG_STATION: station_q <= cfg_data[7:0];
				REG_WINDOW:  window_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Frame and confirmation state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			xor_q      <= '0;
			uid_q      <= '0;
			good_q     <= 1'b0;
			prev_uid_q <= '1;
			elapsed_q  <= '0;
		end else if (fire_s1) begin
			if (kind_s1 == KIND_TICK) begin
				if (elapsed_q < ELAPSED_MAX) begin
					elapsed_q <= elapsed_q + 17'd1;
				end
			end else begin
				xor_q  <= xor_next;
				uid_q  <= uid_next;
				good_q <= good_next;
				if (hdr_bad || last_byte) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (last_byte && good_next) begin
					if (store_new) begin
						prev_uid_q <= uid_next;
						elapsed_q  <= '0;
					end else begin
						prev_uid_q <= '0;
					end
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (byte_fire && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire && last_byte) begin
			status_q   <= status_next;
			card_uid_q <= uid_next;
		end
	end

endmodule

FILE: sv/cup_checker.sv
// Port-level checker for the card UID frame parser, with its bind.
module cup_checker
	import cup_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] card_uid
);

	// A stalled result keeps its value until the transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(card_uid))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_STORED || status == ST_CONFIRMED ||
			status == ST_BAD_CHECKSUM))
		else $error("undefined status code");

	// The input side only stalls behind a pending result.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no pending result");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

endmodule

bind card_uid_frame_parser cup_checker u_cup_checker (.*);
